/* rtl/tcon_pkg.sv */
// shared constants, operation codes and control/status structs for the text console
package tcon_pkg;

	// default screen geometry
	localparam int DEF_COLUMNS = 80;
	localparam int DEF_ROWS    = 25;

	// field widths of the request and result items
	localparam int CHAR_W  = 8;
	localparam int COLOR_W = 8;
	localparam int CELL_W  = 16;
	localparam int COL_FW  = 7;
	localparam int ROW_FW  = 5;

	// character codes that start a new line
	localparam logic [CHAR_W-1:0] CH_LF = 8'd10;
	localparam logic [CHAR_W-1:0] CH_CR = 8'd13;

	// cell value after reset and attribute after reset
	localparam logic [CELL_W-1:0]  BLANK_CELL  = 16'h0720;
	localparam logic [COLOR_W-1:0] COLOR_RESET = 8'd7;

	// datapath operations issued by the controller
	localparam logic [2:0] OP_NONE   = 3'd0;
	localparam logic [2:0] OP_CLEAR  = 3'd1;
	localparam logic [2:0] OP_LOAD   = 3'd2;
	localparam logic [2:0] OP_EXEC   = 3'd3;
	localparam logic [2:0] OP_SHIFT  = 3'd4;
	localparam logic [2:0] OP_RESULT = 3'd5;

	typedef struct packed {
		logic [2:0] op;
	} cmd_t;

	typedef struct packed {
		logic clear_last;
		logic shift_last;
		logic need_scroll;
		logic out_free;
	} stat_t;

endpackage

/* rtl/text_console_putchar_scroll.sv */
// top level of the text console: stream ports, color register, controller and datapath
// a put or read result passes the EXEC state, then SCROLL if the put scrolls, and is
// registered in the RESULT state once the output is free; a new request is taken only
// after that result is registered; the scroll moves one cell per cycle through the
// single-write-port screen memory; reset: cursor to 0,0 and color to 7, then a clearing
// pass writes every cell to 0x0720 while s_axis_tready stays low
module text_console_putchar_scroll #(
	parameter int COLUMNS = tcon_pkg::DEF_COLUMNS,
	parameter int ROWS    = tcon_pkg::DEF_ROWS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [7:0]  cfg_wr_data,   // text_color
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // char_code[7:0], read_col[14:8], read_row[19:15], zero
	input  logic        s_axis_tuser,  // func
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata   // cell_entry[15:0], cursor_col[22:16],
	                                   // cursor_row[27:23], scrolled[28], zero
);
	import tcon_pkg::*;

	cmd_t               cmd;
	stat_t              stat;
	logic [COLOR_W-1:0] color_q;
	logic [CELL_W-1:0]  out_cell;
	logic [COL_FW-1:0]  out_col;
	logic [ROW_FW-1:0]  out_row;
	logic               out_scrolled;

	// attribute register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_q <= COLOR_RESET;
		end else if (cfg_wr_en) begin
			color_q <= cfg_wr_data;
		end
	end

	tcon_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_valid (s_axis_tvalid),
		.s_ready (s_axis_tready),
		.stat    (stat),
		.cmd     (cmd)
	);

	tcon_dp #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.color        (color_q),
		.in_func      (s_axis_tuser),
		.in_char      (s_axis_tdata[7:0]),
		.in_rcol      (s_axis_tdata[14:8]),
		.in_rrow      (s_axis_tdata[19:15]),
		.out_ready    (m_axis_tready),
		.out_valid    (m_axis_tvalid),
		.out_cell     (out_cell),
		.out_col      (out_col),
		.out_row      (out_row),
		.out_scrolled (out_scrolled)
	);

	// result packing
	assign m_axis_tdata = {3'b000, out_scrolled, out_row, out_col, out_cell};

endmodule

/* rtl/tcon_ctrl.sv */
// controller state machine: clearing pass, request sequencing, scroll and result handoff
module tcon_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_valid,
	output logic            s_ready,
	input  tcon_pkg::stat_t stat,
	output tcon_pkg::cmd_t  cmd
);
	import tcon_pkg::*;

	localparam logic [2:0] ST_CLEAR  = 3'd0;
	localparam logic [2:0] ST_IDLE   = 3'd1;
	localparam logic [2:0] ST_EXEC   = 3'd2;
	localparam logic [2:0] ST_SCROLL = 3'd3;
	localparam logic [2:0] ST_RESULT = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_nxt;

	// next state and command decode
	always_comb begin
		state_nxt = state_q;
		cmd.op    = OP_NONE;
		s_ready   = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				cmd.op = OP_CLEAR;
				if (stat.clear_last) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_IDLE: begin
				s_ready = 1'b1;
				if (s_valid) begin
					cmd.op    = OP_LOAD;
					state_nxt = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.op    = OP_EXEC;
				state_nxt = stat.need_scroll ? ST_SCROLL : ST_RESULT;
			end
			ST_SCROLL: begin
				cmd.op = OP_SHIFT;
				if (stat.shift_last) begin
					state_nxt = ST_RESULT;
				end
			end
			ST_RESULT: begin
				if (stat.out_free) begin
					cmd.op    = OP_RESULT;
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_CLEAR;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	a_ready_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_ready |-> state_q == ST_IDLE)
		else $error("request taken outside idle");

	a_scroll_from_exec: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(state_q == ST_SCROLL) |-> $past(state_q) == ST_EXEC && $past(stat.need_scroll))
		else $error("scroll entered without a scrolling request");

	a_clear_then_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLEAR && stat.clear_last |=> state_q == ST_IDLE)
		else $error("clearing pass did not finish into idle");

endmodule

/* rtl/tcon_dp.sv */
// datapath: screen memory, cursor, sweep pointer, scroll pipeline and result register
module tcon_dp #(
	parameter int COLUMNS = tcon_pkg::DEF_COLUMNS,
	parameter int ROWS    = tcon_pkg::DEF_ROWS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tcon_pkg::cmd_t                cmd,
	output tcon_pkg::stat_t               stat,
	input  logic [tcon_pkg::COLOR_W-1:0]  color,
	input  logic                          in_func,
	input  logic [tcon_pkg::CHAR_W-1:0]   in_char,
	input  logic [tcon_pkg::COL_FW-1:0]   in_rcol,
	input  logic [tcon_pkg::ROW_FW-1:0]   in_rrow,
	input  logic                          out_ready,
	output logic                          out_valid,
	output logic [tcon_pkg::CELL_W-1:0]   out_cell,
	output logic [tcon_pkg::COL_FW-1:0]   out_col,
	output logic [tcon_pkg::ROW_FW-1:0]   out_row,
	output logic                          out_scrolled
);
	import tcon_pkg::*;

	localparam int CELLS = COLUMNS * ROWS;
	localparam int AW    = $clog2(CELLS);
	localparam int PW    = AW + 1;
	localparam int CW    = $clog2(COLUMNS);
	localparam int RW    = $clog2(ROWS);
	localparam logic [31:0] COLS32 = 32'(COLUMNS);
	localparam logic [31:0] ROWS32 = 32'(ROWS);

	// screen memory
	logic [CELL_W-1:0] mem [CELLS];
	logic [CELL_W-1:0] rd_q;
	logic              mem_we;
	logic [AW-1:0]     mem_wa;
	logic [CELL_W-1:0] mem_wd;
	logic              mem_re;
	logic [AW-1:0]     mem_ra;

	// latched request
	logic              func_q;
	logic [CHAR_W-1:0] ch_q;
	logic [COL_FW-1:0] rcol_q;
	logic [ROW_FW-1:0] rrow_q;

	// cursor and sweep pointer
	logic [CW-1:0] cur_col_q;
	logic [RW-1:0] cur_row_q;
	logic [PW-1:0] ptr_q;
	logic          scrolled_q;

	// pending scroll write
	logic          wr_s1;
	logic          wr_zero_s1;
	logic [AW-1:0] wr_addr_s1;

	logic          out_valid_q;
	logic [CELL_W-1:0] out_cell_q;
	logic [COL_FW-1:0] out_col_q;
	logic [ROW_FW-1:0] out_row_q;
	logic          out_scrolled_q;

	logic          newline;
	logic          col_last;
	logic          row_last;
	logic          in_range;
	logic          copy_phase;
	logic [AW-1:0] cur_addr;
	logic [AW-1:0] item_addr;
	logic [PW-1:0] shift_dst;
	logic [CW+COL_FW-1:0] col_ext;
	logic [RW+ROW_FW-1:0] row_ext;

	// request decode and address arithmetic
	assign newline    = (ch_q == CH_LF) || (ch_q == CH_CR);
	assign col_last   = cur_col_q == CW'(COLUMNS - 1);
	assign row_last   = cur_row_q == RW'(ROWS - 1);
	assign in_range   = (32'(rcol_q) < COLS32) && (32'(rrow_q) < ROWS32);
	assign cur_addr   = AW'(32'(cur_row_q) * COLS32 + 32'(cur_col_q));
	assign item_addr  = AW'(32'(rrow_q) * COLS32 + 32'(rcol_q));
	assign copy_phase = ptr_q < PW'(CELLS);
	assign shift_dst  = ptr_q - PW'(COLUMNS);
	assign col_ext    = {{COL_FW{1'b0}}, cur_col_q};
	assign row_ext    = {{ROW_FW{1'b0}}, cur_row_q};

	// status to the controller
	assign stat.clear_last  = ptr_q == PW'(CELLS - 1);
	assign stat.shift_last  = ptr_q == PW'(CELLS + COLUMNS - 1);
	assign stat.need_scroll = !func_q && (newline || col_last) && row_last;
	assign stat.out_free    = !out_valid_q || out_ready;

	// memory port selection
	always_comb begin
		mem_we = 1'b0;
		mem_wa = ptr_q[AW-1:0];
		mem_wd = BLANK_CELL;
		mem_re = 1'b0;
		mem_ra = ptr_q[AW-1:0];
		case (cmd.op)
			OP_CLEAR: begin
				mem_we = 1'b1;
			end
			OP_EXEC: begin
				if (!func_q && !newline) begin
					mem_we = 1'b1;
					mem_wa = cur_addr;
					mem_wd = {color, ch_q};
				end
				if (func_q && in_range) begin
					mem_re = 1'b1;
					mem_ra = item_addr;
				end
			end
			OP_SHIFT: begin
				mem_re = copy_phase;
			end
			default: begin
				mem_re = 1'b0;
			end
		endcase
		// row move or bottom row zeroing, written in the cycle after the read
		if (wr_s1) begin
			mem_we = 1'b1;
			mem_wa = wr_addr_s1;
			mem_wd = wr_zero_s1 ? '0 : rd_q;
		end
	end

	// memory array with registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rd_q <= mem[mem_ra];
		end
	end

	// request payload latch
	always_ff @(posedge clk) begin
		if (cmd.op == OP_LOAD) begin
			func_q <= in_func;
			ch_q   <= in_char;
			rcol_q <= in_rcol;
			rrow_q <= in_rrow;
		end
	end

	// scroll write stage payload
	always_ff @(posedge clk) begin
		wr_zero_s1 <= !copy_phase;
		wr_addr_s1 <= shift_dst[AW-1:0];
	end

	// cursor, pointer and scroll control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_col_q  <= '0;
			cur_row_q  <= '0;
			ptr_q      <= '0;
			scrolled_q <= 1'b0;
			wr_s1      <= 1'b0;
		end else begin
			wr_s1 <= cmd.op == OP_SHIFT;
			case (cmd.op)
				OP_CLEAR, OP_SHIFT: begin
					ptr_q <= ptr_q + PW'(1);
				end
				OP_LOAD: begin
					scrolled_q <= 1'b0;
				end
				OP_EXEC: begin
					if (!func_q) begin
						if (newline || col_last) begin
							cur_col_q <= '0;
							if (row_last) begin
								scrolled_q <= 1'b1;
								ptr_q      <= PW'(COLUMNS);
							end else begin
								cur_row_q <= cur_row_q + RW'(1);
							end
						end else begin
							cur_col_q <= cur_col_q + CW'(1);
						end
					end
				end
				default: begin
					scrolled_q <= scrolled_q;
				end
			endcase
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.op == OP_RESULT) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (cmd.op == OP_RESULT) begin
			out_cell_q     <= (func_q && in_range) ? rd_q : '0;
			out_col_q      <= col_ext[COL_FW-1:0];
			out_row_q      <= row_ext[ROW_FW-1:0];
			out_scrolled_q <= scrolled_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_cell     = out_cell_q;
	assign out_col      = out_col_q;
	assign out_row      = out_row_q;
	assign out_scrolled = out_scrolled_q;

	a_cursor_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cur_col_q) < COLS32 && 32'(cur_row_q) < ROWS32)
		else $error("cursor outside the screen");

	a_no_write_clash: assert property (@(posedge clk) disable iff (!arst_n)
		wr_s1 |-> cmd.op != OP_EXEC && cmd.op != OP_CLEAR)
		else $error("scroll write collides with another write");

	a_scroll_bottom_row: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_RESULT && scrolled_q |-> row_last && cur_col_q == '0)
		else $error("scroll left cursor off the bottom row start");

	a_no_result_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_RESULT |-> !out_valid_q || out_ready)
		else $error("result overwritten before it was taken");

endmodule
